FILE: hw/rtl/assert_macros.svh
// Assertion macros for the RTL modules (included by the hashing core).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

FILE: hw/rtl/sha1sh_pkg.sv
// Package with types and constants of the SHA-1 stream hasher.
`default_nettype none
package sha1sh_pkg;
  localparam int unsigned NumIvWords = 5;
  localparam int unsigned QueueDepth = 4;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [31:0] StdIv [5] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                      32'h10325476, 32'hC3D2E1F0};
  localparam logic [7:0] PadByte = 8'h80;

  typedef struct packed {
    logic       start_message;
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       end_message;
  } item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        final_word;
  } result_t;

  typedef struct packed {
    logic [2:0]  idx;
    logic [31:0] data;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_LEN, ST_ROUND, ST_ADD, ST_EMIT
  } state_t;
endpackage
`default_nettype wire

FILE: hw/rtl/sha1sh_if.sv
// Valid/ready channel interfaces.
`default_nettype none
interface sha1sh_item_if;
  logic valid;
  logic ready;
  sha1sh_pkg::item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sha1sh_result_if;
  logic valid;
  logic ready;
  sha1sh_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sha1sh_cfg_if;
  logic valid;
  logic ready;
  sha1sh_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/sha1_stream_hasher.sv
// Top level of the SHA-1 stream hasher.
// A byte item is taken while the core is idle; a full block then runs through the
// single-round compression unit, a final block through padding and length steps too,
// and the digest leaves as five words. Rounds run one per cycle; no byte is taken meanwhile.
// Reset (synchronous, active high) loads the standard IV and clears the length.
`default_nettype none
module sha1_stream_hasher #(
  parameter int unsigned QueueDepth = sha1sh_pkg::QueueDepth
) (
  input wire logic clk,
  input wire logic rst,
  sha1sh_item_if.sink     in_ch,
  sha1sh_cfg_if.sink      cfg,
  sha1sh_result_if.source out_ch
);
  logic [31:0] iv [5];
  sha1sh_pkg::item_t head;
  logic avail, pop;

  assign cfg.ready = 1'b1;

  // IV registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 5; i++) iv[i] <= sha1sh_pkg::StdIv[i];
    end else if (cfg.valid && cfg.data.idx < 3'd5) begin
      iv[cfg.data.idx] <= cfg.data.data;
    end
  end

  sha1sh_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst, .in_ch, .pop, .head, .not_empty(avail));

  sha1sh_core u_core (
    .clk, .rst, .item(head), .item_avail(avail), .item_pop(pop), .iv, .out_ch);
endmodule
`default_nettype wire

FILE: hw/rtl/sha1sh_queue.sv
// Short item queue between the front end and the hashing core.
`default_nettype none
module sha1sh_queue #(
  parameter int unsigned Depth = sha1sh_pkg::QueueDepth
) (
  input  wire logic clk,
  input  wire logic rst,
  sha1sh_item_if.sink   in_ch,
  input  wire logic     pop,
  output sha1sh_pkg::item_t head,
  output logic          not_empty
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  sha1sh_pkg::item_t mem [Depth];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0] count;
  logic push;

  assign push = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (count != (AW+1)'(Depth));
  assign not_empty = (count != '0);
  assign head = mem[rd_ptr];

  // Storage writes.
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_ch.data;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0; rd_ptr <= '0; count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(Depth-1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == AW'(Depth-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/sha1sh_core.sv
// Hashing core: block buffer, padding, 80-round compression and digest output.
`default_nettype none
`include "assert_macros.svh"
module sha1sh_core (
  input  wire logic clk,
  input  wire logic rst,
  input  wire sha1sh_pkg::item_t item,
  input  wire logic item_avail,
  output logic      item_pop,
  input  wire logic [31:0] iv [5],
  sha1sh_result_if.source out_ch
);
  sha1sh_pkg::state_t state, state_next;
  logic [31:0] chain [5];
  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e;
  logic [63:0] message_bits;
  logic [5:0]  block_fill;
  logic [6:0]  round;
  logic        final_blk;
  logic [2:0]  wnum;
  logic        pend_end;   // End flag waiting behind a full-block compression.
  logic        pad_done;   // Pad byte placed; a second block of zeros and length follows.

  logic [31:0] wt, f, k, tmp, wsched;
  logic        take;
  logic [5:0]  fill_in;
  logic [63:0] bits_in;

  assign take = (state == sha1sh_pkg::ST_IDLE) && item_avail;
  assign item_pop = take;
  assign fill_in = item.start_message ? 6'd0 : block_fill;
  assign bits_in = item.start_message ? 64'd0 : message_bits;

  // Round function with rolling schedule.
  always_comb begin
    wsched = w[13] ^ w[8] ^ w[2] ^ w[0];
    wt = (round < 7'd16) ? w[0] : {wsched[30:0], wsched[31]};
    if (round < 7'd20) begin
      f = d ^ (b & (c ^ d)); k = sha1sh_pkg::K0;
    end else if (round < 7'd40) begin
      f = b ^ c ^ d; k = sha1sh_pkg::K1;
    end else if (round < 7'd60) begin
      f = (b & c) | (b & d) | (c & d); k = sha1sh_pkg::K2;
    end else begin
      f = b ^ c ^ d; k = sha1sh_pkg::K3;
    end
    tmp = {a[26:0], a[31:27]} + f + e + k + wt;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      sha1sh_pkg::ST_IDLE: begin
        if (take) begin
          if (item.byte_valid && fill_in == 6'd63) state_next = sha1sh_pkg::ST_ROUND;
          else if (item.end_message) state_next = sha1sh_pkg::ST_PAD;
        end
      end
      sha1sh_pkg::ST_PAD:
        state_next = (block_fill >= 6'd56) ? sha1sh_pkg::ST_ROUND : sha1sh_pkg::ST_LEN;
      sha1sh_pkg::ST_LEN: state_next = sha1sh_pkg::ST_ROUND;
      sha1sh_pkg::ST_ROUND: if (round == 7'd79) state_next = sha1sh_pkg::ST_ADD;
      sha1sh_pkg::ST_ADD: begin
        if (final_blk) state_next = sha1sh_pkg::ST_EMIT;
        else if (pend_end || pad_done) state_next = sha1sh_pkg::ST_LEN;
        else state_next = sha1sh_pkg::ST_IDLE;
      end
      sha1sh_pkg::ST_EMIT:
        if (out_ch.ready && wnum == 3'd4) state_next = sha1sh_pkg::ST_IDLE;
      default: state_next = sha1sh_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    out_ch.valid = (state == sha1sh_pkg::ST_EMIT);
    out_ch.data.digest_word = chain[wnum];
    out_ch.data.word_number = wnum;
    out_ch.data.final_word = (wnum == 3'd4);
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha1sh_pkg::ST_IDLE;
      for (int i = 0; i < 5; i++) chain[i] <= sha1sh_pkg::StdIv[i];
      message_bits <= '0; block_fill <= '0; round <= '0;
      final_blk <= 1'b0; wnum <= '0; pend_end <= 1'b0;
      pad_done <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        sha1sh_pkg::ST_IDLE: if (take) begin
          if (item.start_message)
            for (int i = 0; i < 5; i++) chain[i] <= iv[i];
          block_fill <= fill_in;
          message_bits <= bits_in;
          pend_end <= item.end_message;
          pad_done <= 1'b0;
          if (item.byte_valid) begin
            if (fill_in[1:0] == 2'd0) w[fill_in[5:2]] <= {item.data_byte, 24'd0};
            else w[fill_in[5:2]] <= w[fill_in[5:2]] |
                 (32'(item.data_byte) << (5'd24 - {fill_in[1:0], 3'd0}));
            block_fill <= fill_in + 6'd1;
            message_bits <= bits_in + 64'd8;
          end
          if (item.byte_valid && fill_in == 6'd63) begin
            final_blk <= 1'b0; round <= '0;
            a <= item.start_message ? iv[0] : chain[0];
            b <= item.start_message ? iv[1] : chain[1];
            c <= item.start_message ? iv[2] : chain[2];
            d <= item.start_message ? iv[3] : chain[3];
            e <= item.start_message ? iv[4] : chain[4];
          end
        end
        sha1sh_pkg::ST_PAD: begin
          // Pad byte and zero fill past it.
          for (int i = 0; i < 16; i++) begin
            if (i == int'(block_fill[5:2])) begin
              if (block_fill[1:0] == 2'd0) w[i] <= {sha1sh_pkg::PadByte, 24'd0};
              else w[i] <= w[i] | (32'(sha1sh_pkg::PadByte) <<
                                   (5'd24 - {block_fill[1:0], 3'd0}));
            end else if (i > int'(block_fill[5:2])) w[i] <= '0;
          end
          pend_end <= 1'b0;
          round <= '0;
          a <= chain[0]; b <= chain[1]; c <= chain[2]; d <= chain[3]; e <= chain[4];
          final_blk <= !(block_fill >= 6'd56);
          if (block_fill >= 6'd56) pad_done <= 1'b1;
        end
        sha1sh_pkg::ST_LEN: begin
          // Length words; a second block starts from zeros, a full-block end from the pad byte.
          for (int i = 0; i < 14; i++)
            if (pad_done || pend_end) w[i] <= (i == 0 && pend_end) ?
                {sha1sh_pkg::PadByte, 24'd0} : 32'd0;
          w[14] <= message_bits[63:32];
          w[15] <= message_bits[31:0];
          pend_end <= 1'b0;
          round <= '0; final_blk <= 1'b1;
          a <= chain[0]; b <= chain[1]; c <= chain[2]; d <= chain[3]; e <= chain[4];
        end
        sha1sh_pkg::ST_ROUND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= wt;
          e <= d; d <= c; c <= {b[1:0], b[31:2]}; b <= a; a <= tmp;
          round <= round + 7'd1;
        end
        sha1sh_pkg::ST_ADD: begin
          chain[0] <= chain[0] + a; chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c; chain[3] <= chain[3] + d;
          chain[4] <= chain[4] + e;
          wnum <= '0;
          if (!final_blk && pend_end) block_fill <= '0;
        end
        sha1sh_pkg::ST_EMIT: if (out_ch.ready) begin
          wnum <= wnum + 3'd1;
          // After the last word the next message starts from the IV.
          if (wnum == 3'd4) begin
            wnum <= '0;
            for (int i = 0; i < 5; i++) chain[i] <= iv[i];
            block_fill <= '0;
            message_bits <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_NEVER(a_wnum_range, clk, rst, wnum > 3'd4)
  `ASSERT_NEVER(a_round_range, clk, rst, round > 7'd80)
  `ASSERT_IMPL(a_pop_idle, clk, rst, item_pop |-> state == sha1sh_pkg::ST_IDLE)
endmodule
`default_nettype wire
